// ===== hdl/dtyp_pkg.sv =====
// Shared constants, types and tables for the direction-to-yaw/pitch pipeline.
// No dependencies; every other file in hdl/ imports this package.
`default_nettype none

package dtyp_pkg;

  // Angle format and CORDIC depth
  localparam int ANGLE_ITERATIONS = 20;
  localparam int ANGLE_FRAC_BITS  = 16;
  localparam int TAB_FRAC         = 28;

  // Datapath widths
  localparam int IN_W    = 32;  // point coordinate
  localparam int DW      = 33;  // coordinate difference
  localparam int HALF_W  = 31;  // |dx|, |dz| after optional halving
  localparam int SQ_W    = 2 * HALF_W;
  localparam int SUM_W   = SQ_W + 1;
  localparam int WW      = 64;  // wide operand into the normalizer
  localparam int IDX_W   = $clog2(WW);
  localparam int HYP_W   = 32;  // integer square root result
  localparam int NW      = 41;  // normalized operand, |v| < 2^40
  localparam int XW      = 44;  // CORDIC x/y with gain headroom
  localparam int ZW      = 40;  // angle accumulator
  localparam int YAW_W   = 26;
  localparam int PITCH_W = 24;

  // Normalization targets
  localparam int NORM_MSB = 39;  // max magnitude lands in [2^39, 2^40)
  localparam int SUM_MSB  = 60;  // scaled sum of squares at least 2^60
  localparam int SCALE_W  = 5;   // power-of-four scale, at most 30

  // Pipeline latencies, in register stages
  localparam int SQ_ITERS   = HYP_W;
  localparam int LAT_HYP    = 5;
  localparam int LAT_SQRT   = SQ_ITERS;
  localparam int LAT_NORM   = 4;
  localparam int LAT_CORDIC = ANGLE_ITERATIONS + 1;
  localparam int LAT_PIPE   = 1 + LAT_HYP + LAT_SQRT + LAT_NORM + LAT_CORDIC;
  localparam int YAW_DELAY  = LAT_HYP + LAT_SQRT;

  typedef logic signed [ZW-1:0] angle_t;

  localparam int     RND_SH   = TAB_FRAC - ANGLE_FRAC_BITS;
  localparam angle_t RND_HALF = angle_t'(1) <<< (RND_SH - 1);
  localparam angle_t Z_POS90  = angle_t'(90) <<< TAB_FRAC;
  localparam angle_t Z_NEG90  = -(angle_t'(90) <<< TAB_FRAC);
  localparam angle_t DEG_P90  = angle_t'(90) <<< ANGLE_FRAC_BITS;
  localparam angle_t DEG_N90  = -(angle_t'(90) <<< ANGLE_FRAC_BITS);
  localparam angle_t DEG_P180 = angle_t'(180) <<< ANGLE_FRAC_BITS;
  localparam angle_t DEG_N180 = -(angle_t'(180) <<< ANGLE_FRAC_BITS);

  // Pre-rotation applied when the vector lies in the left half plane
  typedef enum logic [1:0] {
    QUAD_NONE,
    QUAD_POS90,
    QUAD_NEG90
  } quad_e;

  // Normalizer to CORDIC hand-off
  typedef struct packed {
    logic signed [NW-1:0] x;
    logic signed [NW-1:0] y;
    quad_e                quad;
    logic                 zero;
  } norm_t;

  // Position of the highest set bit (0 when v is zero)
  function automatic logic [IDX_W-1:0] msb_index(input logic [WW-1:0] v);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int k = 0; k < WW; k++) begin
      if (v[k]) idx = IDX_W'(k);
    end
    return idx;
  endfunction

  // atan(2^-i) in degrees, Q28
  function automatic angle_t atan_q28(input logic [4:0] idx);
    angle_t a;
    case (idx)
      5'd0:  a = angle_t'(64'sd12079595520);
      5'd1:  a = angle_t'(64'sd7131001626);
      5'd2:  a = angle_t'(64'sd3767825416);
      5'd3:  a = angle_t'(64'sd1912607013);
      5'd4:  a = angle_t'(64'sd960014949);
      5'd5:  a = angle_t'(64'sd480475470);
      5'd6:  a = angle_t'(64'sd240296363);
      5'd7:  a = angle_t'(64'sd120155514);
      5'd8:  a = angle_t'(64'sd60078674);
      5'd9:  a = angle_t'(64'sd30039451);
      5'd10: a = angle_t'(64'sd15019740);
      5'd11: a = angle_t'(64'sd7509872);
      5'd12: a = angle_t'(64'sd3754936);
      5'd13: a = angle_t'(64'sd1877468);
      5'd14: a = angle_t'(64'sd938734);
      5'd15: a = angle_t'(64'sd469367);
      5'd16: a = angle_t'(64'sd234684);
      5'd17: a = angle_t'(64'sd117342);
      5'd18: a = angle_t'(64'sd58671);
      5'd19: a = angle_t'(64'sd29335);
      5'd20: a = angle_t'(64'sd14668);
      5'd21: a = angle_t'(64'sd7334);
      5'd22: a = angle_t'(64'sd3667);
      5'd23: a = angle_t'(64'sd1833);
      5'd24: a = angle_t'(64'sd917);
      5'd25: a = angle_t'(64'sd458);
      5'd26: a = angle_t'(64'sd229);
      5'd27: a = angle_t'(64'sd115);
      5'd28: a = angle_t'(64'sd57);
      5'd29: a = angle_t'(64'sd29);
      5'd30: a = angle_t'(64'sd14);
      default: a = angle_t'(64'sd7);
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/direction_to_yaw_pitch.sv =====
// Top level: difference vector, yaw and pitch arctangent pipelines, output register.
// Depends on dtyp_pkg, dtyp_hyp, dtyp_isqrt, dtyp_norm, dtyp_cordic.
`default_nettype none

// Turns a pair of 3-D points (signed, 8 fraction bits) into viewing angles in degrees
// with 16 fraction bits: yaw = atan2(dz, dx) - 90 in [-270, 90] and
// pitch = -atan2(dy, sqrt(dx^2 + dz^2)) in [-90, 90], negative pitch looking up.
// Equal points give yaw -90 and pitch 0. The block takes one point pair per cycle
// while the output is not stalled. The pitch path sets the pipeline depth: 5 stages
// of square/sum/scale, 32 stages of integer square root (one root bit per stage),
// 4 normalizer stages and a 20-stage CORDIC plus rounding; yaw runs its own
// normalizer and CORDIC in parallel and waits in a delay line to line up with pitch.
// A stalled output freezes the pipeline only while its last stage holds a result, so
// in_ready_o stays high whenever the output register is empty, taken, or the last
// stage is empty. in_ready_o depends combinationally on out_ready_i.

module direction_to_yaw_pitch import dtyp_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [IN_W-1:0]    from_x_i,
  input  logic signed [IN_W-1:0]    from_y_i,
  input  logic signed [IN_W-1:0]    from_z_i,
  input  logic signed [IN_W-1:0]    to_x_i,
  input  logic signed [IN_W-1:0]    to_y_i,
  input  logic signed [IN_W-1:0]    to_z_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [YAW_W-1:0]   yaw_deg_o,
  output logic signed [PITCH_W-1:0] pitch_deg_o
);

  // ---------------------------------------------------------------------------
  // Flow control: one enable for every stage
  // ---------------------------------------------------------------------------
  logic [LAT_PIPE-1:0] vld_q;
  logic                last_vld;
  logic                pipe_adv;
  logic                out_load;
  logic                out_valid_q, out_valid_d;

  assign last_vld   = vld_q[LAT_PIPE-1];
  assign pipe_adv   = !last_vld || !out_valid_q || out_ready_i;
  assign out_load   = pipe_adv && last_vld;
  assign in_ready_o = pipe_adv;

  // valid bits ride alongside the data stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (pipe_adv) begin
      vld_q <= {vld_q[LAT_PIPE-2:0], in_valid_i};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: difference vector at full width, cannot overflow
  // ---------------------------------------------------------------------------
  logic signed [DW-1:0] dx_q, dy_q, dz_q;

  always_ff @(posedge clk_i) begin
    if (pipe_adv) begin
      dx_q <= DW'(to_x_i) - DW'(from_x_i);
      dy_q <= DW'(to_y_i) - DW'(from_y_i);
      dz_q <= DW'(to_z_i) - DW'(from_z_i);
    end
  end

  // ---------------------------------------------------------------------------
  // Yaw: atan2(dz, dx), clamp to +/-180, subtract 90, delay to meet pitch
  // ---------------------------------------------------------------------------
  norm_t  yaw_norm;
  angle_t yaw_ang, yaw_clip, yaw_fix;

  dtyp_norm u_yaw_norm (
    .clk_i  (clk_i),
    .en_i   (pipe_adv),
    .x_i    (WW'(dx_q)),
    .y_i    (WW'(dz_q)),
    .norm_o (yaw_norm)
  );

  dtyp_cordic u_yaw_cordic (
    .clk_i   (clk_i),
    .en_i    (pipe_adv),
    .norm_i  (yaw_norm),
    .angle_o (yaw_ang)
  );

  assign yaw_clip = (yaw_ang < DEG_N180) ? DEG_N180 :
                    (yaw_ang > DEG_P180) ? DEG_P180 : yaw_ang;
  assign yaw_fix  = yaw_clip - DEG_P90;

  logic signed [YAW_W-1:0] yaw_dly_q [YAW_DELAY];

  always_ff @(posedge clk_i) begin
    if (pipe_adv) begin
      yaw_dly_q[0] <= YAW_W'(yaw_fix);
      for (int k = 1; k < YAW_DELAY; k++) begin
        yaw_dly_q[k] <= yaw_dly_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Pitch: horizontal length by integer root, then -atan2(dy', hyp)
  // ---------------------------------------------------------------------------
  logic        [WW-1:0]    hyp_sum;
  logic signed [WW-1:0]    hyp_vy, root_vy;
  logic        [HYP_W-1:0] hyp_root;
  norm_t                   pitch_norm;
  angle_t                  pitch_ang, pitch_neg, pitch_fix;

  dtyp_hyp u_hyp (
    .clk_i (clk_i),
    .en_i  (pipe_adv),
    .dx_i  (dx_q),
    .dy_i  (dy_q),
    .dz_i  (dz_q),
    .sum_o (hyp_sum),
    .vy_o  (hyp_vy)
  );

  dtyp_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (pipe_adv),
    .val_i  (hyp_sum),
    .side_i (hyp_vy),
    .root_o (hyp_root),
    .side_o (root_vy)
  );

  dtyp_norm u_pitch_norm (
    .clk_i  (clk_i),
    .en_i   (pipe_adv),
    .x_i    (WW'(hyp_root)),
    .y_i    (root_vy),
    .norm_o (pitch_norm)
  );

  dtyp_cordic u_pitch_cordic (
    .clk_i   (clk_i),
    .en_i    (pipe_adv),
    .norm_i  (pitch_norm),
    .angle_o (pitch_ang)
  );

  assign pitch_neg = -pitch_ang;
  assign pitch_fix = (pitch_neg < DEG_N90) ? DEG_N90 :
                     (pitch_neg > DEG_P90) ? DEG_P90 : pitch_neg;

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic signed [YAW_W-1:0]   yaw_q;
  logic signed [PITCH_W-1:0] pitch_q;

  assign out_valid_d = out_load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      yaw_q   <= yaw_dly_q[YAW_DELAY-1];
      pitch_q <= PITCH_W'(pitch_fix);
    end
  end

  assign out_valid_o = out_valid_q;
  assign yaw_deg_o   = yaw_q;
  assign pitch_deg_o = pitch_q;

endmodule

`default_nettype wire

// ===== hdl/dtyp_hyp.sv =====
// Horizontal length prep: |dx|,|dz| halving, squares, sum and power-of-four scaling.
// Five register stages; depends on dtyp_pkg.
`default_nettype none

module dtyp_hyp import dtyp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [DW-1:0] dx_i,
  input  logic signed [DW-1:0] dy_i,
  input  logic signed [DW-1:0] dz_i,
  output logic        [WW-1:0] sum_o,
  output logic signed [WW-1:0] vy_o
);

  // stage 1: magnitudes, halve when either reaches 2^31
  logic [DW-1:0] ax, az, ax_h, az_h;
  logic          halve;
  logic [HALF_W-1:0] ax1_q, az1_q;
  logic signed [DW-1:0] dy1_q;

  assign ax    = dx_i[DW-1] ? -dx_i : dx_i;
  assign az    = dz_i[DW-1] ? -dz_i : dz_i;
  assign halve = (|ax[DW-1:HALF_W]) | (|az[DW-1:HALF_W]);
  assign ax_h  = halve ? (ax >> 1) : ax;
  assign az_h  = halve ? (az >> 1) : az;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax1_q <= ax_h[HALF_W-1:0];
      az1_q <= az_h[HALF_W-1:0];
      dy1_q <= halve ? (dy_i >>> 1) : dy_i;
    end
  end

  // stage 2: squares
  logic [SQ_W-1:0]      sqx2_q, sqz2_q;
  logic signed [DW-1:0] dy2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sqx2_q <= ax1_q * ax1_q;
      sqz2_q <= az1_q * az1_q;
      dy2_q  <= dy1_q;
    end
  end

  // stage 3: sum of squares
  logic [SUM_W-1:0]     sum3_q;
  logic signed [DW-1:0] dy3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum3_q <= SUM_W'(sqx2_q) + SUM_W'(sqz2_q);
      dy3_q  <= dy2_q;
    end
  end

  // stage 4: smallest j with sum * 4^j >= 2^60
  logic [IDX_W-1:0]   msb;
  logic [IDX_W:0]     jt;
  logic [SCALE_W-1:0] scale;
  logic [SUM_W-1:0]     sum4_q;
  logic signed [DW-1:0] dy4_q;
  logic [SCALE_W-1:0]   scale4_q;

  assign msb   = msb_index(WW'(sum3_q));
  assign jt    = (IDX_W+1)'(SUM_MSB + 1) - (IDX_W+1)'(msb);
  assign scale = ((sum3_q == '0) || (msb >= IDX_W'(SUM_MSB))) ? '0 : jt[SCALE_W:1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum4_q   <= sum3_q;
      dy4_q    <= dy3_q;
      scale4_q <= scale;
    end
  end

  // stage 5: apply the scale to the sum and to dy
  logic        [WW-1:0] sum5_q;
  logic signed [WW-1:0] vy5_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum5_q <= WW'(sum4_q) << {scale4_q, 1'b0};
      vy5_q  <= WW'(dy4_q) <<< scale4_q;
    end
  end

  assign sum_o = sum5_q;
  assign vy_o  = vy5_q;

endmodule

`default_nettype wire

// ===== hdl/dtyp_isqrt.sv =====
// Pipelined integer square root, one result bit per stage, with a side payload.
// Depends on dtyp_pkg.
`default_nettype none

module dtyp_isqrt import dtyp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic        [WW-1:0] val_i,
  input  logic signed [WW-1:0] side_i,
  output logic     [HYP_W-1:0] root_o,
  output logic signed [WW-1:0] side_o
);

  logic        [WW-1:0] rem_q  [SQ_ITERS];
  logic        [WW-1:0] res_q  [SQ_ITERS];
  logic signed [WW-1:0] side_q [SQ_ITERS];

  for (genvar g = 0; g < SQ_ITERS; g++) begin : g_step
    localparam logic [WW-1:0] BIT = WW'(1) << (WW - 2 - 2 * g);
    logic        [WW-1:0] rem_in, res_in, trial;
    logic signed [WW-1:0] side_in;
    logic                 take;

    if (g == 0) begin : g_first
      assign rem_in  = val_i;
      assign res_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[g-1];
      assign res_in  = res_q[g-1];
      assign side_in = side_q[g-1];
    end

    // res is a multiple of 2*BIT here, so res + BIT is a plain OR
    assign trial = res_in | BIT;
    assign take  = (rem_in >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g]  <= take ? (rem_in - trial) : rem_in;
        res_q[g]  <= take ? ((res_in >> 1) + BIT) : (res_in >> 1);
        side_q[g] <= side_in;
      end
    end
  end

  assign root_o = res_q[SQ_ITERS-1][HYP_W-1:0];
  assign side_o = side_q[SQ_ITERS-1];

endmodule

`default_nettype wire

// ===== hdl/dtyp_norm.sv =====
// Operand normalizer ahead of the CORDIC: scale so max |x|,|y| is in [2^39, 2^40),
// then fold the left half plane by +/-90 degrees. Four stages; depends on dtyp_pkg.
`default_nettype none

module dtyp_norm import dtyp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [WW-1:0] x_i,
  input  logic signed [WW-1:0] y_i,
  output norm_t                norm_o
);

  localparam logic signed [NW-1:0] NW_MIN = {1'b1, {(NW-1){1'b0}}};

  // stage 1: larger magnitude, zero detect
  logic [WW-1:0] mx, my;
  logic signed [WW-1:0] x1_q, y1_q;
  logic [WW-1:0]        m1_q;
  logic                 zero1_q;

  assign mx = x_i[WW-1] ? -x_i : x_i;
  assign my = y_i[WW-1] ? -y_i : y_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q    <= x_i;
      y1_q    <= y_i;
      m1_q    <= (mx > my) ? mx : my;
      zero1_q <= (x_i == '0) && (y_i == '0);
    end
  end

  // stage 2: leading one position
  logic signed [WW-1:0] x2_q, y2_q;
  logic [IDX_W-1:0]     p2_q;
  logic                 zero2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x2_q    <= x1_q;
      y2_q    <= y1_q;
      p2_q    <= msb_index(m1_q);
      zero2_q <= zero1_q;
    end
  end

  // stage 3: grow exactly or shrink with flooring shifts
  logic                 grow;
  logic [IDX_W-1:0]     lsh, rsh;
  logic signed [WW-1:0] xw, yw;
  logic signed [NW-1:0] x3_q, y3_q;
  logic                 zero3_q;

  assign grow = (p2_q <= IDX_W'(NORM_MSB));
  assign lsh  = IDX_W'(NORM_MSB) - p2_q;
  assign rsh  = p2_q - IDX_W'(NORM_MSB);
  assign xw   = grow ? (x2_q <<< lsh) : (x2_q >>> rsh);
  assign yw   = grow ? (y2_q <<< lsh) : (y2_q >>> rsh);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x3_q    <= NW'(xw);
      y3_q    <= NW'(yw);
      zero3_q <= zero2_q;
    end
  end

  // stage 4: a floored negative can land on -2^40, take one more shift; then fold
  logic                 fix;
  logic signed [NW-1:0] xc, yc, xf, yf;
  quad_e                quad;
  norm_t                norm_q;

  assign fix = (x3_q == NW_MIN) || (y3_q == NW_MIN);
  assign xc  = fix ? (x3_q >>> 1) : x3_q;
  assign yc  = fix ? (y3_q >>> 1) : y3_q;

  always_comb begin
    xf   = xc;
    yf   = yc;
    quad = QUAD_NONE;
    if (xc[NW-1]) begin
      if (!yc[NW-1]) begin
        xf   = yc;
        yf   = -xc;
        quad = QUAD_POS90;
      end else begin
        xf   = -yc;
        yf   = xc;
        quad = QUAD_NEG90;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      norm_q <= '{x: xf, y: yf, quad: quad, zero: zero3_q};
    end
  end

  assign norm_o = norm_q;

endmodule

`default_nettype wire

// ===== hdl/dtyp_cordic.sv =====
// Vectoring CORDIC, one micro-rotation per stage, then rounding to output degrees.
// Depends on dtyp_pkg (atan table, widths, norm_t).
`default_nettype none

module dtyp_cordic import dtyp_pkg::*; (
  input  logic   clk_i,
  input  logic   en_i,
  input  norm_t  norm_i,
  output angle_t angle_o
);

  logic signed [XW-1:0] x_q    [ANGLE_ITERATIONS];
  logic signed [XW-1:0] y_q    [ANGLE_ITERATIONS];
  angle_t               z_q    [ANGLE_ITERATIONS];
  logic                 zero_q [ANGLE_ITERATIONS];
  angle_t               z_init;

  always_comb begin
    case (norm_i.quad)
      QUAD_POS90: z_init = Z_POS90;
      QUAD_NEG90: z_init = Z_NEG90;
      default:    z_init = '0;
    endcase
  end

  for (genvar g = 0; g < ANGLE_ITERATIONS; g++) begin : g_iter
    logic signed [XW-1:0] x_in, y_in, x_sh, y_sh;
    angle_t               z_in, step;
    logic                 zero_in, rot;

    if (g == 0) begin : g_first
      assign x_in    = XW'(norm_i.x);
      assign y_in    = XW'(norm_i.y);
      assign z_in    = z_init;
      assign zero_in = norm_i.zero;
    end else begin : g_next
      assign x_in    = x_q[g-1];
      assign y_in    = y_q[g-1];
      assign z_in    = z_q[g-1];
      assign zero_in = zero_q[g-1];
    end

    assign step = atan_q28(5'(g));
    assign rot  = (y_in > 0);
    assign x_sh = y_in >>> g;
    assign y_sh = x_in >>> g;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[g]    <= rot ? (x_in + x_sh) : (x_in - x_sh);
        y_q[g]    <= rot ? (y_in - y_sh) : (y_in + y_sh);
        z_q[g]    <= rot ? (z_in + step) : (z_in - step);
        zero_q[g] <= zero_in;
      end
    end
  end

  // round half up from Q28 to the output fraction; zero vector gives 0
  angle_t z_rnd, angle_q;

  assign z_rnd = (z_q[ANGLE_ITERATIONS-1] + RND_HALF) >>> RND_SH;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      angle_q <= zero_q[ANGLE_ITERATIONS-1] ? '0 : z_rnd;
    end
  end

  assign angle_o = angle_q;

endmodule

`default_nettype wire

// ===== hdl/dtyp_checker.sv =====
// Port-level checks for direction_to_yaw_pitch, attached by the bind at the end.
// Depends on dtyp_pkg.
`default_nettype none

module dtyp_checker import dtyp_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic signed [IN_W-1:0]    from_x_i,
  input logic signed [IN_W-1:0]    from_y_i,
  input logic signed [IN_W-1:0]    from_z_i,
  input logic signed [IN_W-1:0]    to_x_i,
  input logic signed [IN_W-1:0]    to_y_i,
  input logic signed [IN_W-1:0]    to_z_i,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic signed [YAW_W-1:0]   yaw_deg_o,
  input logic signed [PITCH_W-1:0] pitch_deg_o
);

  localparam int ONE    = 1 << ANGLE_FRAC_BITS;
  localparam int YAW_LO = -270 * ONE;
  localparam int YAW_HI = 90 * ONE;
  localparam int PIT_LO = -90 * ONE;
  localparam int PIT_HI = 90 * ONE;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(yaw_deg_o) && $stable(pitch_deg_o))
    else $error("output transfer dropped or changed while stalled");

  // an empty output register must never block the input side
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input not ready while output register is empty");

  a_yaw_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (yaw_deg_o >= YAW_LO) && (yaw_deg_o <= YAW_HI))
    else $error("yaw outside [-270, 90]");

  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pitch_deg_o >= PIT_LO) && (pitch_deg_o <= PIT_HI))
    else $error("pitch outside [-90, 90]");

endmodule

bind direction_to_yaw_pitch dtyp_checker u_checker (.*);

`default_nettype wire

// ===== tb/direction_to_yaw_pitch_tb.sv =====
// Self-checking testbench for direction_to_yaw_pitch: random point pairs in, angles out.
// Depends on dtyp_pkg for widths and angle format; predicts results with its own model.

module direction_to_yaw_pitch_tb;
  import dtyp_pkg::*;

  // Run shape
  localparam int RAND_ITEMS   = 630;
  localparam int STALL_AFTER  = 200;          // input transfers before the long hold-off
  localparam int STALL_LEN    = 160;          // well beyond the pipeline depth
  localparam int QUIET_LIMIT  = 2000;         // cycles with no transfer on either side
  localparam int DRAIN_CYCLES = 2 * LAT_PIPE;

  localparam logic signed [IN_W-1:0] MINV = {1'b1, {(IN_W-1){1'b0}}};
  localparam logic signed [IN_W-1:0] MAXV = {1'b0, {(IN_W-1){1'b1}}};

  // CORDIC operands are normalized so the larger magnitude sits in [2^39, 2^40)
  localparam longint unsigned NORM_BOT = 64'd1 << NORM_MSB;
  localparam longint unsigned NORM_TOP = 64'd1 << (NORM_MSB + 1);

  // atan(2^-i) in degrees, 28 fraction bits
  localparam longint ATAN_Q28 [32] = '{
    64'sd12079595520, 64'sd7131001626, 64'sd3767825416, 1912607013,
    960014949, 480475470, 240296363, 120155514,
    60078674, 30039451, 15019740, 7509872,
    3754936, 1877468, 938734, 469367,
    234684, 117342, 58671, 29335,
    14668, 7334, 3667, 1833,
    917, 458, 229, 115,
    57, 29, 14, 7
  };

  typedef struct {
    logic signed [IN_W-1:0] fx, fy, fz;
    logic signed [IN_W-1:0] tx, ty, tz;
  } pt_pair_t;

  typedef struct {
    logic signed [YAW_W-1:0]   yaw;
    logic signed [PITCH_W-1:0] pitch;
  } view_t;

  // DUT signals; every input known from time zero
  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_ready_o;
  logic signed [IN_W-1:0]    from_x_i    = '0;
  logic signed [IN_W-1:0]    from_y_i    = '0;
  logic signed [IN_W-1:0]    from_z_i    = '0;
  logic signed [IN_W-1:0]    to_x_i      = '0;
  logic signed [IN_W-1:0]    to_y_i      = '0;
  logic signed [IN_W-1:0]    to_z_i      = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic signed [YAW_W-1:0]   yaw_deg_o;
  logic signed [PITCH_W-1:0] pitch_deg_o;

  // Stimulus and scoreboard
  pt_pair_t pending_pairs [$];   // point pairs not yet offered
  view_t    angle_expect  [$];   // predicted angles, oldest first
  int       miss_cnt   = 0;
  int       in_xfers   = 0;
  int       quiet_cnt  = 0;

  // Sender and receiver pacing
  int       tx_wait    = 0;
  bit       tx_calm    = 1'b0;   // stretch of back-to-back offers
  logic     tx_next;
  pt_pair_t tx_pair;
  int       rx_wait    = 0;
  bit       rx_calm    = 1'b0;   // stretch of ready held high
  logic     rx_next;
  logic     rx_hold    = 1'b0;   // long hold-off, driven by its own process
  view_t    rx_want;

  direction_to_yaw_pitch u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .from_x_i    (from_x_i),
    .from_y_i    (from_y_i),
    .from_z_i    (from_z_i),
    .to_x_i      (to_x_i),
    .to_y_i      (to_y_i),
    .to_z_i      (to_z_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .yaw_deg_o   (yaw_deg_o),
    .pitch_deg_o (pitch_deg_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Angle predictor
  // ---------------------------------------------------------------------------

  function automatic longint unsigned mag64(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint unsigned peak_mag(input longint a, input longint b);
    return (mag64(a) > mag64(b)) ? mag64(a) : mag64(b);
  endfunction

  function automatic longint clamp64(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Floor of the square root, one result bit per pass
  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned res;
    longint unsigned probe;
    res   = 0;
    probe = 64'd1 << 62;
    while (probe > v) probe = probe >> 2;
    while (probe != 0) begin
      if (v >= res + probe) begin
        v   = v - (res + probe);
        res = (res >> 1) + probe;
      end else begin
        res = res >> 1;
      end
      probe = probe >> 2;
    end
    return res;
  endfunction

  // Vectoring CORDIC: atan2(y, x) in degrees with ANGLE_FRAC_BITS fraction bits
  function automatic longint cordic_deg(input longint x, input longint y);
    longint          z;
    longint          t;
    longint          xs;
    longint          ys;
    longint unsigned m;
    z = 0;
    if (x == 0 && y == 0) return 0;
    m = peak_mag(x, y);
    while (m >= NORM_TOP) begin
      x = x >>> 1;
      y = y >>> 1;
      m = peak_mag(x, y);
    end
    while (m < NORM_BOT) begin
      x = x * 2;
      y = y * 2;
      m = peak_mag(x, y);
    end
    // Left half plane: turn a quarter toward +x first
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        z = longint'(90) <<< TAB_FRAC;
      end else begin
        x = -y;
        y = t;
        z = -(longint'(90) <<< TAB_FRAC);
      end
    end
    for (int i = 0; i < ANGLE_ITERATIONS && i < 32; i++) begin
      xs = y >>> i;
      ys = x >>> i;
      if (y > 0) begin
        x = x + xs;
        y = y - ys;
        z = z + ATAN_Q28[i];
      end else begin
        x = x - xs;
        y = y + ys;
        z = z - ATAN_Q28[i];
      end
    end
    // Round half up into the output fraction width
    return (z + (longint'(1) <<< (TAB_FRAC - ANGLE_FRAC_BITS - 1)))
           >>> (TAB_FRAC - ANGLE_FRAC_BITS);
  endfunction

  function automatic view_t predict_view(input pt_pair_t p);
    longint          one;
    longint          dx, dy, dz;
    longint          yaw, pitch, hyp, vy;
    longint unsigned ax, az, sum;
    int              e;
    int              j;
    view_t           r;
    one = longint'(1) <<< ANGLE_FRAC_BITS;
    dx  = longint'(p.tx) - longint'(p.fx);
    dy  = longint'(p.ty) - longint'(p.fy);
    dz  = longint'(p.tz) - longint'(p.fz);
    ax  = mag64(dx);
    az  = mag64(dz);
    e   = (((ax | az) >> 31) != 0) ? 1 : 0;
    j   = 0;

    yaw = clamp64(cordic_deg(dx, dz), -180 * one, 180 * one) - 90 * one;

    // Horizontal length: halve if too wide, then scale up by a power of four
    ax  = ax >> e;
    az  = az >> e;
    sum = ax * ax + az * az;
    if (sum != 0) begin
      while (sum < (64'd1 << 60) && j < 30) begin
        sum = sum << 2;
        j++;
      end
    end
    hyp   = longint'(root_floor(sum));
    vy    = (dy >>> e) <<< j;
    pitch = clamp64(-cordic_deg(hyp, vy), -90 * one, 90 * one);

    r.yaw   = yaw[YAW_W-1:0];
    r.pitch = pitch[PITCH_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic pt_pair_t mk_pair(
    input logic signed [IN_W-1:0] fx, input logic signed [IN_W-1:0] fy,
    input logic signed [IN_W-1:0] fz, input logic signed [IN_W-1:0] tx,
    input logic signed [IN_W-1:0] ty, input logic signed [IN_W-1:0] tz
  );
    pt_pair_t p;
    p.fx = fx; p.fy = fy; p.fz = fz;
    p.tx = tx; p.ty = ty; p.tz = tz;
    return p;
  endfunction

  // Offset along one axis with a random magnitude scale; sparse makes a third of them zero
  function automatic logic signed [IN_W-1:0] axis_delta(input bit sparse);
    logic signed [IN_W-1:0] m;
    if (sparse && $urandom_range(0, 2) == 0) return '0;
    m = $urandom >> $urandom_range(0, 31);
    return $urandom_range(0, 1) ? -m : m;
  endfunction

  function automatic logic signed [IN_W-1:0] pick_edge();
    case ($urandom_range(0, 5))
      0:       return MINV;
      1:       return MAXV;
      2:       return '0;
      3:       return -1;
      4:       return 1;
      default: return $urandom;
    endcase
  endfunction

  // Mismatch bookkeeping; only the first few are printed
  task automatic report_miss(input string what, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    miss_cnt++;
    if (miss_cnt <= 10)
      $display("mismatch %s: expected %0d, got %0d", what, want, got);
  endtask

  // ---------------------------------------------------------------------------
  // Sender: one item per transfer, random gap drawn after each transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      tx_next = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        // Predict at the transfer, from the payload that was actually on the ports
        angle_expect.push_back(predict_view(tx_pair));
        in_xfers++;
        tx_next = 1'b0;
        if ($urandom_range(0, 31) == 0) tx_calm = ~tx_calm;
        tx_wait = tx_calm ? 0 : $urandom_range(0, 7);
      end
      if (!tx_next) begin
        if (tx_wait > 0) begin
          tx_wait--;
        end else if (pending_pairs.size() > 0) begin
          tx_pair = pending_pairs.pop_front();
          from_x_i <= tx_pair.fx;
          from_y_i <= tx_pair.fy;
          from_z_i <= tx_pair.fz;
          to_x_i   <= tx_pair.tx;
          to_y_i   <= tx_pair.ty;
          to_z_i   <= tx_pair.tz;
          tx_next  = 1'b1;
        end
      end
      in_valid_i <= tx_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: checks each result transfer, then backs off a random number of cycles
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (angle_expect.size() == 0) begin
          report_miss("result with nothing pending, yaw", '0, yaw_deg_o);
        end else begin
          rx_want = angle_expect.pop_front();
          if (yaw_deg_o !== rx_want.yaw)
            report_miss("yaw_deg", rx_want.yaw, yaw_deg_o);
          if (pitch_deg_o !== rx_want.pitch)
            report_miss("pitch_deg", rx_want.pitch, pitch_deg_o);
        end
        if ($urandom_range(0, 31) == 0) rx_calm = ~rx_calm;
        rx_wait = rx_calm ? 0 : $urandom_range(0, 7);
      end
      if (rx_hold) begin
        rx_next = 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        rx_next = 1'b0;
      end else begin
        rx_next = 1'b1;
      end
      out_ready_i <= rx_next;
    end
  end

  // Long receiver hold-off while the sender keeps offering: the pipeline fills
  // and in_ready_o must drop
  initial begin
    while (in_xfers < STALL_AFTER) @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (STALL_LEN) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        quiet_cnt = 0;
      else
        quiet_cnt++;
      if (quiet_cnt >= QUIET_LIMIT) begin
        $display("timeout after %0d idle cycles", quiet_cnt);
        $display("status: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    pt_pair_t p;

    // Directed: zero vector, extremes, each axis, left half plane, vertical,
    // tiny vectors and the halving threshold of the horizontal length
    pending_pairs.push_back(mk_pair(0, 0, 0, 0, 0, 0));
    pending_pairs.push_back(mk_pair(MAXV, MINV, MAXV, MAXV, MINV, MAXV));
    pending_pairs.push_back(mk_pair(MINV, MINV, MINV, MAXV, MAXV, MAXV));
    pending_pairs.push_back(mk_pair(MAXV, MAXV, MAXV, MINV, MINV, MINV));
    pending_pairs.push_back(mk_pair(0, 0, 0, 256, 0, 0));
    pending_pairs.push_back(mk_pair(0, 0, 0, -256, 0, 0));   // atan2(0, neg) is +180
    pending_pairs.push_back(mk_pair(0, 0, 0, 0, 0, 256));
    pending_pairs.push_back(mk_pair(0, 0, 0, 0, 0, -256));
    pending_pairs.push_back(mk_pair(0, 0, 0, -300, 0, 500));
    pending_pairs.push_back(mk_pair(0, 0, 0, -300, 0, -500));
    pending_pairs.push_back(mk_pair(0, 0, 0, 0, 1000, 0));   // straight up
    pending_pairs.push_back(mk_pair(0, 0, 0, 0, -1000, 0));  // straight down
    pending_pairs.push_back(mk_pair(0, 0, 0, 1, 1, 1));
    pending_pairs.push_back(mk_pair(0, 0, 0, -1, 0, -1));
    pending_pairs.push_back(mk_pair(0, 0, 0, -1, 0, 0));
    pending_pairs.push_back(mk_pair(0, 0, 0, MINV, 3, 0));   // |dx| reaches 2^31
    pending_pairs.push_back(mk_pair(0, 0, 0, MAXV, 5, 0));   // just below it
    pending_pairs.push_back(mk_pair(0, MAXV, 0, MINV, MINV, MINV));
    pending_pairs.push_back(mk_pair(MINV, 0, MINV, MAXV, MINV, MAXV));
    pending_pairs.push_back(mk_pair(0, MINV, 0, 0, MAXV, 0));
    pending_pairs.push_back(mk_pair(0, 0, 0, MAXV, MAXV, MAXV));

    // Random: mostly offsets from a random origin at mixed scales, plus raw and edge values
    for (int n = 0; n < RAND_ITEMS; n++) begin
      p.fx = $urandom;
      p.fy = $urandom;
      p.fz = $urandom;
      case ($urandom_range(0, 4))
        0: begin
          p.tx = $urandom;
          p.ty = $urandom;
          p.tz = $urandom;
        end
        1: begin
          p.tx = p.fx + axis_delta(1'b0);
          p.ty = p.fy + axis_delta(1'b0);
          p.tz = p.fz + axis_delta(1'b0);
        end
        2: begin
          p.tx = p.fx + axis_delta(1'b1);
          p.ty = p.fy + axis_delta(1'b1);
          p.tz = p.fz + axis_delta(1'b1);
        end
        3: begin
          p = mk_pair(pick_edge(), pick_edge(), pick_edge(),
                      pick_edge(), pick_edge(), pick_edge());
        end
        default: begin
          p.tx = p.fx + $signed($urandom_range(0, 8)) - 4;
          p.ty = p.fy + $signed($urandom_range(0, 8)) - 4;
          p.tz = p.fz + $signed($urandom_range(0, 8)) - 4;
        end
      endcase
      pending_pairs.push_back(p);
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every item to be sent and every result to come back
    while (pending_pairs.size() != 0 || in_valid_i || angle_expect.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (miss_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
